// File: design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and SHA-256 helper functions for the stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int SHS_WORD_W      = 32;
   localparam int SHS_LEN_W       = 61;
   localparam int SHS_QUEUE_DEPTH = 4;

   localparam logic [SHS_WORD_W-1:0] SHS_MARKER = 32'h8000_0000;

   // round constants
   localparam logic [31:0] SHS_ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // initial hash values
   localparam logic [31:0] SHS_INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // one classified word on its way from the front to the core
   typedef struct packed {
      logic [SHS_WORD_W-1:0] word;   // message word, marker already merged
      logic [2:0]            bytes;  // bytes it adds to the length, 0..4
      logic                  last;   // final word of the message
      logic                  mark;   // marker word still has to follow
   } shs_entry_type;

   typedef enum logic [2:0] {
      SHS_TAKE,
      SHS_MARK,
      SHS_PAD,
      SHS_LEN_LO,
      SHS_ROUND,
      SHS_UPDATE,
      SHS_SEND
   } shs_state_type;

   function automatic logic [31:0] shs_rotr(input logic [31:0] x, input int n);
      shs_rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] shs_big_sigma0(input logic [31:0] x);
      shs_big_sigma0 = shs_rotr(x, 2) ^ shs_rotr(x, 13) ^ shs_rotr(x, 22);
   endfunction

   function automatic logic [31:0] shs_big_sigma1(input logic [31:0] x);
      shs_big_sigma1 = shs_rotr(x, 6) ^ shs_rotr(x, 11) ^ shs_rotr(x, 25);
   endfunction

   function automatic logic [31:0] shs_small_sigma0(input logic [31:0] x);
      shs_small_sigma0 = shs_rotr(x, 7) ^ shs_rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] shs_small_sigma1(input logic [31:0] x);
      shs_small_sigma1 = shs_rotr(x, 17) ^ shs_rotr(x, 19) ^ (x >> 10);
   endfunction

   // where the core goes once a word is stored and no compression is due
   function automatic shs_state_type shs_follow(input logic fin, input logic mark,
                                                input logic len_done);
      priority if (!fin)     shs_follow = SHS_TAKE;
      else if (mark)         shs_follow = SHS_MARK;
      else if (len_done)     shs_follow = SHS_SEND;
      else                   shs_follow = SHS_PAD;
   endfunction

endpackage

// File: design/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Input side: classifies each incoming transaction into a queue entry.
// ----------------------------------------------------------------------------
module shs_front
   import shs_pkg::*;
(
   input  logic [31:0]   req_data_word,
   input  logic [2:0]    req_byte_count,
   input  logic          req_last,
   input  logic          req_push,
   output logic          req_full,
   output logic          q_push,
   output shs_entry_type q_entry,
   input  logic          q_full
);

   logic [2:0]  count;
   logic [5:0]  shift;
   logic [31:0] keep;

   // clamp the byte count: non-last items always carry four bytes
   always_comb begin
      if (!req_last || (req_byte_count > 3'd4)) begin
         count = 3'd4;
      end else begin
         count = req_byte_count;
      end
      shift = {count, 3'b000};
      keep  = ~(32'hffff_ffff >> shift);
   end

   // merge the end marker into a short last word
   always_comb begin
      q_entry.bytes = count;
      q_entry.last  = req_last;
      q_entry.mark  = req_last && (count == 3'd4);
      if (req_last && (count != 3'd4)) begin
         q_entry.word = (req_data_word & keep) | (SHS_MARKER >> shift);
      end else begin
         q_entry.word = req_data_word;
      end
   end

   assign q_push   = req_push && !q_full;
   assign req_full = q_full;

endmodule

// File: design/shs_fifo.sv
// ----------------------------------------------------------------------------
// shs_fifo
// Short show-ahead queue between the front and the compression core.
// ----------------------------------------------------------------------------
module shs_fifo
   import shs_pkg::*;
#(
   parameter int DEPTH = SHS_QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  shs_entry_type wr_entry,
   output logic          full,
   input  logic          pop,
   output shs_entry_type rd_entry,
   output logic          empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   shs_entry_type  mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign rd_entry = mem_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// File: design/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Back side: block collection, padding, 64-round compression, digest output.
// ----------------------------------------------------------------------------
module shs_core
   import shs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  shs_entry_type q_entry,
   output logic          q_pop,
   output logic [31:0]   rsp_digest_word,
   output logic [2:0]    rsp_word_index,
   output logic          rsp_last_word,
   output logic          rsp_empty,
   input  logic          rsp_pop
);

   shs_state_type          state_ff, state_in;
   logic [31:0]            hash_ff  [8];
   logic [31:0]            v_ff     [8];
   logic [31:0]            w_ff     [16];
   logic [3:0]             fill_ff, fill_in;
   logic [SHS_LEN_W-1:0]   len_ff, len_in;
   logic [5:0]             round_ff;
   logic [2:0]             idx_ff;
   logic                   fin_ff, fin_in;
   logic                   mark_ff, mark_in;
   logic                   done_ff, done_in;

   logic                   push_en;
   logic [31:0]            push_word;
   logic                   send_pop;
   logic                   start_round;
   logic                   shift_en;
   logic [31:0]            shift_word;
   logic [31:0]            sched;
   logic [31:0]            t1, t2;
   logic [31:0]            len_hi, len_lo;

   assign send_pop = (state_ff == SHS_SEND) && rsp_pop;
   assign len_hi   = len_ff[SHS_LEN_W-1:SHS_LEN_W-32];
   assign len_lo   = {len_ff[SHS_LEN_W-33:0], 3'b000};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SHS_TAKE: begin
            if (!q_empty) begin
               if (fill_ff == 4'd15) begin
                  state_in = SHS_ROUND;
               end else begin
                  state_in = shs_follow(q_entry.last, q_entry.mark, done_ff);
               end
            end
         end
         SHS_MARK: begin
            state_in = (fill_ff == 4'd15) ? SHS_ROUND : SHS_PAD;
         end
         SHS_PAD: begin
            priority if (fill_ff == 4'd14) state_in = SHS_LEN_LO;
            else if (fill_ff == 4'd15)     state_in = SHS_ROUND;
            else                           state_in = SHS_PAD;
         end
         SHS_LEN_LO: begin
            state_in = SHS_ROUND;
         end
         SHS_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = SHS_UPDATE;
            end
         end
         SHS_UPDATE: begin
            state_in = shs_follow(fin_ff, mark_ff, done_ff);
         end
         SHS_SEND: begin
            if (rsp_pop && (idx_ff == 3'd7)) begin
               state_in = SHS_TAKE;
            end
         end
         default: begin
            state_in = SHS_TAKE;
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      push_en   = 1'b0;
      push_word = '0;
      q_pop     = 1'b0;
      len_in    = len_ff;
      fin_in    = fin_ff;
      mark_in   = mark_ff;
      done_in   = done_ff;
      unique case (state_ff)
         SHS_TAKE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               push_en   = 1'b1;
               push_word = q_entry.word;
               len_in    = len_ff + SHS_LEN_W'(q_entry.bytes);
               fin_in    = q_entry.last;
               mark_in   = q_entry.mark;
            end
         end
         SHS_MARK: begin
            push_en   = 1'b1;
            push_word = SHS_MARKER;
            mark_in   = 1'b0;
         end
         SHS_PAD: begin
            push_en   = 1'b1;
            push_word = (fill_ff == 4'd14) ? len_hi : '0;
         end
         SHS_LEN_LO: begin
            push_en   = 1'b1;
            push_word = len_lo;
            done_in   = 1'b1;
         end
         SHS_ROUND, SHS_UPDATE, SHS_SEND: begin
            push_en = 1'b0;
         end
         default: begin
            push_en = 1'b0;
         end
      endcase
   end

   assign fill_in     = push_en ? fill_ff + 1'b1 : fill_ff;
   assign start_round = (state_in == SHS_ROUND) && (state_ff != SHS_ROUND);

   // message schedule and one compression round
   always_comb begin
      sched = w_ff[0] + shs_small_sigma0(w_ff[1]) + w_ff[9] + shs_small_sigma1(w_ff[14]);
      t1    = v_ff[7] + shs_big_sigma1(v_ff[4])
            + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
            + SHS_ROUND_K[round_ff] + w_ff[0];
      t2    = shs_big_sigma0(v_ff[0])
            + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      shift_en   = push_en || (state_ff == SHS_ROUND);
      shift_word = (state_ff == SHS_ROUND) ? sched : push_word;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SHS_TAKE;
         fill_ff  <= '0;
         len_ff   <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         round_ff <= start_round ? '0 : round_ff + 1'b1;
         if (send_pop && (idx_ff == 3'd7)) begin
            len_ff  <= '0;
            fin_ff  <= 1'b0;
            mark_ff <= 1'b0;
            done_ff <= 1'b0;
            idx_ff  <= '0;
         end else begin
            len_ff  <= len_in;
            fin_ff  <= fin_in;
            mark_ff <= mark_in;
            done_ff <= done_in;
            idx_ff  <= send_pop ? idx_ff + 1'b1 : idx_ff;
         end
      end
   end

   // hash words: fold in each block, reload after the digest is delivered
   always_ff @(posedge clock) begin
      if (reset || (send_pop && (idx_ff == 3'd7))) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= SHS_INIT_H[i];
         end
      end else if (state_ff == SHS_UPDATE) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + v_ff[i];
         end
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      if (start_round) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= hash_ff[i];
         end
      end else if (state_ff == SHS_ROUND) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   // block words as a shift line: collect words, then slide the schedule
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= shift_word;
      end
   end

   assign rsp_empty       = (state_ff != SHS_SEND);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

endmodule

// File: design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte message streamed in as 32-bit big-endian words.
// ----------------------------------------------------------------------------
// Push message words on req_*; mark the final word with req_last (it may hold
// 0..4 bytes, earlier words always count as 4). After the final word the block
// pads the message, finishes the last one or two blocks and presents the eight
// digest words, hash word A first, on rsp_* for popping; rsp_last_word flags
// the eighth. Words are taken into a small queue while the core compresses or
// waits on rsp_pop. The core moves queued words into the block one by one;
// every sixteenth word starts a compression (64 rounds on a single round unit
// plus a fold into the hash) and no word leaves the queue until it ends. The
// final word is followed by the marker word where needed, zero words and two
// length words, and one or two compressions run before the digest appears.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
   import shs_pkg::*;
#(
   parameter int QUEUE_DEPTH = SHS_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   input  logic        req_push,
   output logic        req_full,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   shs_entry_type wr_entry;
   shs_entry_type rd_entry;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   // classify incoming transactions
   shs_front u_front (
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .req_push       (req_push),
      .req_full       (req_full),
      .q_push         (q_push),
      .q_entry        (wr_entry),
      .q_full         (q_full)
   );

   // decouple front and core
   shs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_entry (rd_entry),
      .empty    (q_empty)
   );

   // compress and deliver the digest
   shs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_entry         (rd_entry),
      .q_pop           (q_pop),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

endmodule

// File: tb/sha256_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking bench for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
// Messages are queued as 32-bit words. A clocked driver pushes them into the
// block and a clocked monitor pops the digest words. Each accepted word also
// goes into a bench-side SHA-256 model, and that model queues the eight
// expected digest words whenever a message ends. A directed set comes first:
// the empty message, short final words, byte counts above four, junk in the
// unused bytes and a message whose length field spills into a second block.
// Random messages follow. Both sides idle in short random bursts, except
// near the end of the run.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

   localparam int          STALL_LIMIT = 2000;
   localparam int          DRAIN_CYCLES = 200;
   localparam int          CALM_ITEMS = 24;
   localparam int          RANDOM_ITEMS = 106;
   localparam logic [31:0] MARK_WORD = 32'h8000_0000;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
   } msg_word_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_exp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;

   msg_word_type   word_q[$];
   digest_exp_type digest_q[$];
   digest_exp_type rsp_want;

   // bench-side hash state
   logic [31:0] chain_h [8];
   logic [31:0] blk_buf [16];
   int unsigned blk_fill;
   logic [60:0] msg_len;

   int items_total = 0;
   int items_accepted = 0;
   int msgs_done = 0;
   int digests_checked = 0;
   int mismatches = 0;
   int send_gap = 0;
   int pop_gap = 0;
   int stall_count = 0;

   sha256_stream_hasher u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last        (req_last),
      .req_push        (req_push),
      .req_full        (req_full),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // restart the chaining value for a new message
   task automatic restart_chain();
      for (int i = 0; i < 8; i++) chain_h[i] = IV_WORDS[i];
      for (int i = 0; i < 16; i++) blk_buf[i] = '0;
      blk_fill = 0;
      msg_len  = '0;
   endtask

   // fold one full 64-byte block into the chaining value
   task automatic compress_chain();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = blk_buf[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_CONST[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic load_word(input logic [31:0] w);
      blk_buf[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
         compress_chain();
         blk_fill = 0;
      end
   endtask

   // advance the hash on one accepted word; on the final word pad and queue the digest
   task automatic absorb_item(input msg_word_type it);
      int unsigned    nbytes;
      logic [31:0]    keep;
      logic [63:0]    bit_len;
      digest_exp_type dw;
      nbytes = (it.count > 3'd4 || !it.last) ? 4 : it.count;
      msg_len = msg_len + 61'(nbytes);
      if (!it.last) begin
         load_word(it.data);
         return;
      end
      if (nbytes == 4) begin
         load_word(it.data);
         load_word(MARK_WORD);
      end else begin
         keep = (nbytes == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * nbytes));
         load_word((it.data & keep) | (MARK_WORD >> (8 * nbytes)));
      end
      // no room left for the length: close this block first
      if (blk_fill > 14) begin
         while (blk_fill != 0) load_word(32'h0);
      end
      while (blk_fill < 14) load_word(32'h0);
      bit_len = {msg_len, 3'b000};
      load_word(bit_len[63:32]);
      load_word(bit_len[31:0]);
      for (int j = 0; j < 8; j++) begin
         dw.word  = chain_h[j];
         dw.index = 3'(j);
         dw.last  = (j == 7);
         digest_q.push_back(dw);
      end
      restart_chain();
   endtask

   task automatic add_word(input logic [31:0] data, input logic [2:0] count, input logic last);
      msg_word_type it;
      it.data  = data;
      it.count = count;
      it.last  = last;
      word_q.push_back(it);
      items_total++;
   endtask

   // drive the request side; record each accepted transaction in the model
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            absorb_item(word_q.pop_front());
            items_accepted++;
            if (req_last) msgs_done++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (word_q.size() > 0) begin
            req_data_word  <= word_q[0].data;
            req_byte_count <= word_q[0].count;
            req_last       <= word_q[0].last;
            req_push       <= 1'b1;
            if (items_accepted + CALM_ITEMS < items_total && $urandom_range(0, 6) == 0)
               send_gap = $urandom_range(1, 5);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // pop digest words and compare each against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (digest_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected digest word %h index %0d last %b",
                           rsp_digest_word, rsp_word_index, rsp_last_word);
            end else begin
               rsp_want = digest_q.pop_front();
               digests_checked++;
               if (rsp_digest_word !== rsp_want.word || rsp_word_index !== rsp_want.index ||
                   rsp_last_word !== rsp_want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              rsp_want.word, rsp_want.index, rsp_want.last,
                              rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (items_accepted + CALM_ITEMS < items_total && $urandom_range(0, 5) == 0)
               pop_gap = $urandom_range(1, 5);
         end
      end
   end

   // end the run when neither side moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int          rand_items;
      int          len_words;
      logic [31:0] data;
      logic [2:0]  count;
      restart_chain();

      // empty message, junk in the unused bytes
      add_word(32'hffff_ffff, 3'd0, 1'b1);
      // three bytes with junk in the last byte
      add_word(32'h6162_63ff, 3'd3, 1'b1);
      // non-last words count as four bytes, whether short or above four
      add_word(32'hffff_ffff, 3'd0, 1'b0);
      add_word(32'h1234_5678, 3'd6, 1'b0);
      add_word(32'h0000_0000, 3'd1, 1'b1);
      // byte counts above four
      add_word(32'h8000_0001, 3'd7, 1'b0);
      add_word(32'hdead_beef, 3'd5, 1'b1);
      // full final word, then two bytes
      add_word(32'h0000_0000, 3'd4, 1'b1);
      add_word(32'hffff_ffff, 3'd2, 1'b1);
      // fifteen words in the block: the length spills into a second block
      for (int i = 0; i < 14; i++)
         add_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'(i % 8), 1'b0);
      add_word(32'ha5a5_a5a5, 3'd3, 1'b1);

      // random messages, lengths clustered near block boundaries
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: len_words = $urandom_range(16, 40);
            1: len_words = $urandom_range(12, 16);
            default: len_words = $urandom_range(0, 11);
         endcase
         // cut the final message short so the item budget is met exactly
         if (rand_items + len_words + 1 > RANDOM_ITEMS)
            len_words = RANDOM_ITEMS - rand_items - 1;
         for (int i = 0; i <= len_words; i++) begin
            data = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hffff_ffff : 32'h0)
                                               : $urandom;
            if (i < len_words) begin
               count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
               add_word(data, count, 1'b0);
            end else begin
               count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
               add_word(data, count, 1'b1);
            end
            rand_items++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (items_accepted == items_total);
      wait (digest_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d messages in %0d words; %0d digest words checked",
               msgs_done, items_accepted, digests_checked);
      if (mismatches == 0 && digest_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d digest words never seen", mismatches, digest_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
design/shs_pkg.sv
design/shs_front.sv
design/shs_fifo.sv
design/shs_core.sv
design/sha256_stream_hasher.sv
tb/sha256_stream_hasher_tb.sv
